// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mpbm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpbm_pkg
// Types and constants of the multi-pattern byte matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mpbm_pkg;

    localparam int MAX_STATES    = 256;
    localparam int MAX_PATTERNS  = 32;
    localparam int ALPHABET_SIZE = 256;

    localparam int NODE_W  = $clog2(MAX_STATES);
    localparam int SYM_W   = $clog2(ALPHABET_SIZE);
    localparam int EADDR_W = NODE_W + SYM_W;
    localparam int MASK_W  = 32;
    localparam int CNT_W   = 9;
    localparam int PCNT_W  = 6;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_BUILD = 2'd2;
    localparam logic [1:0] OP_SCAN  = 2'd3;

    localparam logic [1:0] KIND_BUILD_OK   = 2'd0;
    localparam logic [1:0] KIND_BUILD_FAIL = 2'd1;
    localparam logic [1:0] KIND_SCAN       = 2'd2;
    localparam logic [1:0] KIND_SCAN_REJ   = 2'd3;

    typedef struct packed {
        logic              present;
        logic [NODE_W-1:0] target;
    } t_edge_word;

    typedef struct packed {
        logic               we;
        logic [EADDR_W-1:0] addr;
        t_edge_word         wdata;
    } t_edge_req;

    typedef struct packed {
        logic [NODE_W-1:0] queue;
        logic [NODE_W-1:0] fail;
        logic [MASK_W-1:0] mask;
    } t_node_word;

    typedef struct packed {
        logic              we_queue;
        logic              we_fail;
        logic              we_mask;
        logic [NODE_W-1:0] addr;
        t_node_word        wdata;
    } t_node_req;

endpackage

`default_nettype wire

// ===== hw/rtl/mpbm_edge_ram.sv =====
// ----------------------------------------------------------------------------
// mpbm_edge_ram
// Goto table: one word per (state, symbol), one port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbm_edge_ram (
    input  wire logic                  i_clk,
    input  wire mpbm_pkg::t_edge_req   i_req,
    output mpbm_pkg::t_edge_word       o_rdata
);
    import mpbm_pkg::*;

    t_edge_word r_mem [1 << EADDR_W];
    t_edge_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/mpbm_node_ram.sv =====
// ----------------------------------------------------------------------------
// mpbm_node_ram
// Per-state store: BFS queue slot, failure link and output mask, with
// field write enables, one port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbm_node_ram (
    input  wire logic                  i_clk,
    input  wire mpbm_pkg::t_node_req   i_req,
    output mpbm_pkg::t_node_word       o_rdata
);
    import mpbm_pkg::*;

    t_node_word r_mem [MAX_STATES];
    t_node_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we_queue) begin
            r_mem[i_req.addr].queue <= i_req.wdata.queue;
        end
        if (i_req.we_fail) begin
            r_mem[i_req.addr].fail <= i_req.wdata.fail;
        end
        if (i_req.we_mask) begin
            r_mem[i_req.addr].mask <= i_req.wdata.mask;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/multi_pattern_byte_matcher_core.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_core
// Aho-Corasick matcher: pattern load, failure-link build, byte scan.
// ----------------------------------------------------------------------------
// Usage:
//   An item (opcode, data byte, last) is taken when start is high and busy
//   is low. Clear and load give no result; build and scan give one result,
//   shown on the o_ ports for one cycle with o_strobe high. The receiver
//   cannot stall: a result must be taken in its strobe cycle.
// Steps (busy is high meanwhile; all work goes through the goto RAM and
// the node RAM, one access each per cycle, with registered read data):
//   load  : goto lookup, new edge if absent; mask read-modify-write at end.
//   scan  : goto lookup, then the mask read; each failure link followed
//           adds a link read and a lookup. Rejected if not built.
//   build : a goto read per root symbol, then per queued state a goto
//           read per symbol and, per child, a failure walk and mask merge.
//   clear : all 65536 goto RAM entries, one per cycle; reset runs it too.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_byte_matcher_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    output logic             busy,
    output logic             o_strobe,
    output logic [1:0]       o_result_kind,
    output logic [31:0]      o_match_mask,
    output logic [7:0]       o_machine_state,
    output logic [8:0]       o_state_count
);
    import mpbm_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;
    localparam logic [4:0] S_LD_E   = 5'd2;
    localparam logic [4:0] S_LD_M   = 5'd3;
    localparam logic [4:0] S_NS_E   = 5'd4;
    localparam logic [4:0] S_NS_F   = 5'd5;
    localparam logic [4:0] S_NS_M   = 5'd6;
    localparam logic [4:0] S_B_RRD  = 5'd7;
    localparam logic [4:0] S_B_RCHK = 5'd8;
    localparam logic [4:0] S_B_RQ   = 5'd9;
    localparam logic [4:0] S_B_POP  = 5'd10;
    localparam logic [4:0] S_B_POPW = 5'd11;
    localparam logic [4:0] S_B_SF   = 5'd12;
    localparam logic [4:0] S_B_ERD  = 5'd13;
    localparam logic [4:0] S_B_ECHK = 5'd14;
    localparam logic [4:0] S_B_CM   = 5'd15;
    localparam logic [4:0] S_B_CQ   = 5'd16;

    logic [4:0]         r_state, n_state;
    logic [EADDR_W-1:0] r_sweep, n_sweep;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_last, n_last;
    logic               r_ret, n_ret;
    logic [NODE_W-1:0]  r_cur, n_cur;
    logic [NODE_W-1:0]  r_dst, n_dst;
    logic [SYM_W-1:0]   r_c, n_c;
    logic [NODE_W-1:0]  r_head, n_head;
    logic [NODE_W-1:0]  r_tail, n_tail;
    logic [NODE_W-1:0]  r_sfail, n_sfail;
    logic [NODE_W-1:0]  r_child, n_child;
    logic [MASK_W-1:0]  r_fmask, n_fmask;
    logic [CNT_W-1:0]   r_states_used, n_states_used;
    logic [PCNT_W-1:0]  r_pcount, n_pcount;
    logic [NODE_W-1:0]  r_load_node, n_load_node;
    logic [NODE_W-1:0]  r_scan_node, n_scan_node;
    logic               r_built, n_built;
    logic               r_ovf, n_ovf;

    logic               r_strobe, n_strobe;
    logic [1:0]         r_kind, n_kind;
    logic [MASK_W-1:0]  r_mask, n_mask;
    logic [7:0]         r_mstate, n_mstate;
    logic [CNT_W-1:0]   r_count, n_count;

    t_edge_req  w_ereq;
    t_edge_word w_erd;
    t_node_req  w_nreq;
    t_node_word w_nrd;
    logic       w_accept;

    mpbm_edge_ram u_edge_ram (
        .i_clk   (i_clk),
        .i_req   (w_ereq),
        .o_rdata (w_erd)
    );

    mpbm_node_ram u_node_ram (
        .i_clk   (i_clk),
        .i_req   (w_nreq),
        .o_rdata (w_nrd)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    always_comb begin
        n_state       = r_state;
        n_sweep       = r_sweep;
        n_sym         = r_sym;
        n_last        = r_last;
        n_ret         = r_ret;
        n_cur         = r_cur;
        n_dst         = r_dst;
        n_c           = r_c;
        n_head        = r_head;
        n_tail        = r_tail;
        n_sfail       = r_sfail;
        n_child       = r_child;
        n_fmask       = r_fmask;
        n_states_used = r_states_used;
        n_pcount      = r_pcount;
        n_load_node   = r_load_node;
        n_scan_node   = r_scan_node;
        n_built       = r_built;
        n_ovf         = r_ovf;
        n_strobe      = 1'b0;
        n_kind        = r_kind;
        n_mask        = r_mask;
        n_mstate      = r_mstate;
        n_count       = r_count;
        w_ereq        = '0;
        w_nreq        = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sym  = i_data_byte[SYM_W-1:0];
                    n_last = i_last;
                    case (i_opcode)
                        OP_CLEAR: begin
                            n_state       = S_CLR;
                            n_sweep       = '0;
                            n_states_used = CNT_W'(1);
                            n_pcount      = '0;
                            n_load_node   = '0;
                            n_scan_node   = '0;
                            n_built       = 1'b0;
                            n_ovf         = 1'b0;
                        end
                        OP_LOAD: begin
                            n_built = 1'b0;
                            if (r_pcount >= PCNT_W'(MAX_PATTERNS)) begin
                                n_ovf = 1'b1;
                                if (i_last) begin
                                    n_load_node = '0;
                                end
                            end else begin
                                w_ereq.addr = {r_load_node, i_data_byte[SYM_W-1:0]};
                                n_state     = S_LD_E;
                            end
                        end
                        OP_BUILD: begin
                            if (r_ovf) begin
                                n_built  = 1'b0;
                                n_strobe = 1'b1;
                                n_kind   = KIND_BUILD_FAIL;
                                n_mask   = '0;
                                n_mstate = '0;
                                n_count  = r_states_used;
                            end else begin
                                n_c     = '0;
                                n_head  = '0;
                                n_tail  = '0;
                                n_ret   = 1'b1;
                                n_state = S_B_RRD;
                            end
                        end
                        default: begin
                            if (!r_built) begin
                                n_strobe = 1'b1;
                                n_kind   = KIND_SCAN_REJ;
                                n_mask   = '0;
                                n_mstate = '0;
                                n_count  = '0;
                                if (i_last) begin
                                    n_scan_node = '0;
                                end
                            end else begin
                                n_ret       = 1'b0;
                                n_cur       = r_scan_node;
                                w_ereq.addr = {r_scan_node, i_data_byte[SYM_W-1:0]};
                                n_state     = S_NS_E;
                            end
                        end
                    endcase
                end
            end

            S_CLR: begin
                w_ereq.we      = 1'b1;
                w_ereq.addr    = r_sweep;
                w_nreq.we_mask = 1'b1;
                w_nreq.addr    = r_sweep[NODE_W-1:0];
                n_sweep        = r_sweep + 1'b1;
                if (&r_sweep) begin
                    n_state = S_IDLE;
                end
            end

            S_LD_E: begin
                if (w_erd.present) begin
                    n_dst = w_erd.target;
                end else if (r_states_used < CNT_W'(MAX_STATES)) begin
                    w_ereq.we            = 1'b1;
                    w_ereq.addr          = {r_load_node, r_sym};
                    w_ereq.wdata.present = 1'b1;
                    w_ereq.wdata.target  = r_states_used[NODE_W-1:0];
                    n_dst                = r_states_used[NODE_W-1:0];
                    n_states_used        = r_states_used + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                    n_dst = r_load_node;
                end
                if (r_last) begin
                    w_nreq.addr = n_dst;
                    n_state     = S_LD_M;
                end else begin
                    n_load_node = n_dst;
                    n_state     = S_IDLE;
                end
            end

            S_LD_M: begin
                w_nreq.we_mask    = 1'b1;
                w_nreq.addr       = r_dst;
                w_nreq.wdata.mask = w_nrd.mask | (MASK_W'(1) << r_pcount[4:0]);
                n_pcount          = r_pcount + 1'b1;
                n_load_node       = '0;
                n_state           = S_IDLE;
            end

            // next-state walk, shared by scan and build
            S_NS_E: begin
                if (w_erd.present) begin
                    n_dst       = w_erd.target;
                    w_nreq.addr = w_erd.target;
                    n_state     = S_NS_M;
                end else if (r_cur == '0) begin
                    n_dst       = '0;
                    w_nreq.addr = '0;
                    n_state     = S_NS_M;
                end else begin
                    w_nreq.addr = r_cur;
                    n_state     = S_NS_F;
                end
            end

            S_NS_F: begin
                n_cur       = w_nrd.fail;
                w_ereq.addr = {w_nrd.fail, r_sym};
                n_state     = S_NS_E;
            end

            S_NS_M: begin
                if (!r_ret) begin
                    n_strobe    = 1'b1;
                    n_kind      = KIND_SCAN;
                    n_mask      = w_nrd.mask;
                    n_mstate    = 8'(r_dst);
                    n_count     = '0;
                    n_scan_node = r_last ? '0 : r_dst;
                    n_state     = S_IDLE;
                end else begin
                    n_fmask     = w_nrd.mask;
                    w_nreq.addr = r_child;
                    n_state     = S_B_CM;
                end
            end

            // root children: failure link to root, then enqueue
            S_B_RRD: begin
                w_ereq.addr = {{NODE_W{1'b0}}, r_c};
                n_state     = S_B_RCHK;
            end

            S_B_RCHK: begin
                if (w_erd.present && (w_erd.target != '0)) begin
                    w_nreq.we_fail = 1'b1;
                    w_nreq.addr    = w_erd.target;
                    n_child        = w_erd.target;
                    n_state        = S_B_RQ;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = (&r_c) ? S_B_POP : S_B_RRD;
                end
            end

            S_B_RQ: begin
                w_nreq.we_queue    = 1'b1;
                w_nreq.addr        = r_tail;
                w_nreq.wdata.queue = r_child;
                n_tail             = r_tail + 1'b1;
                n_c                = r_c + 1'b1;
                n_state            = (&r_c) ? S_B_POP : S_B_RRD;
            end

            S_B_POP: begin
                if (r_head == r_tail) begin
                    n_built     = 1'b1;
                    n_scan_node = '0;
                    n_strobe    = 1'b1;
                    n_kind      = KIND_BUILD_OK;
                    n_mask      = '0;
                    n_mstate    = '0;
                    n_count     = r_states_used;
                    n_state     = S_IDLE;
                end else begin
                    w_nreq.addr = r_head;
                    n_state     = S_B_POPW;
                end
            end

            S_B_POPW: begin
                n_cur       = w_nrd.queue;
                n_head      = r_head + 1'b1;
                w_nreq.addr = w_nrd.queue;
                n_state     = S_B_SF;
            end

            S_B_SF: begin
                n_sfail = w_nrd.fail;
                n_c     = '0;
                n_state = S_B_ERD;
            end

            S_B_ERD: begin
                w_ereq.addr = {r_cur, r_c};
                n_state     = S_B_ECHK;
            end

            S_B_ECHK: begin
                if (w_erd.present) begin
                    n_child     = w_erd.target;
                    n_sym       = r_c;
                    n_cur       = r_sfail;
                    w_ereq.addr = {r_sfail, r_c};
                    n_state     = S_NS_E;
                end else begin
                    n_cur   = r_cur;
                    n_c     = r_c + 1'b1;
                    n_state = (&r_c) ? S_B_POP : S_B_ERD;
                end
            end

            // r_dst holds the child's failure state
            S_B_CM: begin
                w_nreq.we_fail    = 1'b1;
                w_nreq.we_mask    = 1'b1;
                w_nreq.addr       = r_child;
                w_nreq.wdata.fail = r_dst;
                w_nreq.wdata.mask = w_nrd.mask | r_fmask;
                n_state           = S_B_CQ;
            end

            S_B_CQ: begin
                w_nreq.we_queue    = 1'b1;
                w_nreq.addr        = r_tail;
                w_nreq.wdata.queue = r_child;
                n_tail             = r_tail + 1'b1;
                n_c                = r_c + 1'b1;
                n_state            = (&r_c) ? S_B_POP : S_B_ERD;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // r_cur must hold the dequeued state across the symbol loop; the walk
    // reuses it, so it is restored from the queue slot below.
    logic [NODE_W-1:0] r_qnode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_sweep       <= '0;
            r_states_used <= CNT_W'(1);
            r_pcount      <= '0;
            r_load_node   <= '0;
            r_scan_node   <= '0;
            r_built       <= 1'b0;
            r_ovf         <= 1'b0;
            r_strobe      <= 1'b0;
            r_head        <= '0;
            r_tail        <= '0;
            r_c           <= '0;
            r_ret         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_sweep       <= n_sweep;
            r_states_used <= n_states_used;
            r_pcount      <= n_pcount;
            r_load_node   <= n_load_node;
            r_scan_node   <= n_scan_node;
            r_built       <= n_built;
            r_ovf         <= n_ovf;
            r_strobe      <= n_strobe;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_c           <= n_c;
            r_ret         <= n_ret;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym    <= n_sym;
        r_last   <= n_last;
        r_dst    <= n_dst;
        r_sfail  <= n_sfail;
        r_child  <= n_child;
        r_fmask  <= n_fmask;
        r_kind   <= n_kind;
        r_mask   <= n_mask;
        r_mstate <= n_mstate;
        r_count  <= n_count;
        if (r_state == S_B_POPW) begin
            r_qnode <= w_nrd.queue;
        end
        // back to the dequeued state once a child is enqueued
        if (r_state == S_B_CQ) begin
            r_cur <= r_qnode;
        end else begin
            r_cur <= n_cur;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_result_kind   = r_kind;
    assign o_match_mask    = r_mask;
    assign o_machine_state = r_mstate;
    assign o_state_count   = r_count;

endmodule

`default_nettype wire

// ===== hw/rtl/mpbm_checker.sv =====
// ----------------------------------------------------------------------------
// mpbm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mpbm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic [1:0]  i_opcode,
    input wire logic        busy,
    input wire logic        o_strobe,
    input wire logic [1:0]  o_result_kind,
    input wire logic [31:0] o_match_mask,
    input wire logic [7:0]  o_machine_state,
    input wire logic [8:0]  o_state_count
);
    import mpbm_pkg::*;

    logic w_clear_taken;
    logic w_scan_res;
    logic w_plain_res;
    logic w_no_match;

    assign w_clear_taken = start && !busy && (i_opcode == OP_CLEAR);
    assign w_scan_res    = o_strobe && ((o_result_kind == KIND_SCAN) ||
                                        (o_result_kind == KIND_SCAN_REJ));
    assign w_plain_res   = o_strobe && (o_result_kind != KIND_SCAN);
    assign w_no_match    = (o_match_mask == '0) && (o_machine_state == '0);

    `MPBM_ASSERT_NXT(a_clear_sweeps, i_clk, i_rst_n, w_clear_taken, busy && !o_strobe, "no sweep")
    `MPBM_ASSERT_IMP(a_scan_no_count, i_clk, i_rst_n, w_scan_res, o_state_count == '0, "scan count")
    `MPBM_ASSERT_IMP(a_build_no_match, i_clk, i_rst_n, w_plain_res, w_no_match, "match data")
    `MPBM_ASSERT_IMP(a_reset_clears, i_clk, i_rst_n, $past(!i_rst_n), busy && !o_strobe, "no clear")

endmodule

bind multi_pattern_byte_matcher_core mpbm_checker u_mpbm_checker (.*);

`default_nettype wire

// ===== tb/multi_pattern_byte_matcher_core_test.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_core_test
// Self-checking bench for the Aho-Corasick byte matcher core.
// ----------------------------------------------------------------------------
// Items are driven on the start/busy command interface. A scoreboard object
// keeps its own trie, failure links and scan state, and predicts each build
// and scan answer as the item is taken. Every strobed result is compared
// with the oldest prediction.
// Stimulus: a short directed opening, then random sessions. Each session
// starts with a clear. Most sessions load overlapping patterns over a small
// alphabet, build, and scan queries. One session fills all 32 pattern slots
// and then overflows them. Another overflows the state store with one long
// pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_byte_matcher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] mask;
        logic [7:0]  mstate;
        logic [8:0]  count;
    } t_match_result;

    class match_scoreboard;
        bit          edge_valid [65536];
        bit [7:0]    edge_dest [65536];
        bit [7:0]    fail_of [256];
        bit [31:0]   hits_at [256];
        bit [7:0]    walk_queue [256];
        int unsigned node_total;
        int unsigned pat_total;
        bit [7:0]    load_at;
        bit [7:0]    scan_at;
        bit          built;
        bit          overflowed;
        t_match_result pending_q [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned builds_ok;
        int unsigned builds_failed;
        int unsigned scans_hit;
        int unsigned scans_rejected;

        function new();
            mismatches = 0;
            results_seen = 0;
            builds_ok = 0;
            builds_failed = 0;
            scans_hit = 0;
            scans_rejected = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (edge_valid[i]) edge_valid[i] = 0;
            foreach (hits_at[i]) hits_at[i] = '0;
            node_total = 1;
            pat_total = 0;
            load_at = '0;
            scan_at = '0;
            built = 0;
            overflowed = 0;
        endfunction

        // goto with failure fallback; root loops to itself
        function bit [7:0] advance(bit [7:0] node, bit [7:0] sym);
            int unsigned guard;
            guard = 0;
            while (guard <= MAX_STATES) begin
                if (edge_valid[{node, sym}]) return edge_dest[{node, sym}];
                if (node == 0) return 8'd0;
                node = fail_of[node];
                guard++;
            end
            return 8'd0;
        endfunction

        function void add_pattern_byte(bit [7:0] sym, bit fin);
            built = 0;
            if (pat_total >= MAX_PATTERNS) begin
                overflowed = 1;
                if (fin) load_at = '0;
                return;
            end
            if (edge_valid[{load_at, sym}]) begin
                load_at = edge_dest[{load_at, sym}];
            end else if (node_total < MAX_STATES) begin
                edge_valid[{load_at, sym}] = 1;
                edge_dest[{load_at, sym}] = node_total[7:0];
                load_at = node_total[7:0];
                node_total++;
            end else begin
                overflowed = 1;
            end
            if (fin) begin
                hits_at[load_at] |= 32'd1 << pat_total;
                pat_total++;
                load_at = '0;
            end
        endfunction

        function void link_failures();
            int unsigned head;
            int unsigned tail;
            bit [7:0]    s;
            bit [7:0]    child;
            bit [7:0]    f;
            head = 0;
            tail = 0;
            fail_of[0] = '0;
            for (int c = 0; c < ALPHABET_SIZE; c++) begin
                if (edge_valid[{8'd0, c[7:0]}] && edge_dest[{8'd0, c[7:0]}] != 0) begin
                    fail_of[edge_dest[{8'd0, c[7:0]}]] = '0;
                    walk_queue[tail] = edge_dest[{8'd0, c[7:0]}];
                    tail++;
                end
            end
            while (head < tail) begin
                s = walk_queue[head];
                head++;
                for (int c = 0; c < ALPHABET_SIZE; c++) begin
                    if (!edge_valid[{s, c[7:0]}]) continue;
                    child = edge_dest[{s, c[7:0]}];
                    f = advance(fail_of[s], c[7:0]);
                    fail_of[child] = f;
                    hits_at[child] |= hits_at[f];
                    if (tail < MAX_STATES) begin
                        walk_queue[tail] = child;
                        tail++;
                    end
                end
            end
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] sym, logic fin);
            t_match_result r;
            r = '{kind: KIND_BUILD_OK, mask: '0, mstate: '0, count: '0};
            case (op)
                OP_CLEAR: wipe();
                OP_LOAD:  add_pattern_byte(sym, fin);
                OP_BUILD: begin
                    r.count = node_total[8:0];
                    if (overflowed) begin
                        built = 0;
                        r.kind = KIND_BUILD_FAIL;
                    end else begin
                        link_failures();
                        built = 1;
                        scan_at = '0;
                        r.kind = KIND_BUILD_OK;
                    end
                    pending_q.insert(pending_q.size(), r);
                end
                default: begin
                    if (!built) begin
                        r.kind = KIND_SCAN_REJ;
                    end else begin
                        scan_at = advance(scan_at, sym);
                        r.kind = KIND_SCAN;
                        r.mask = hits_at[scan_at];
                        r.mstate = scan_at;
                    end
                    if (fin) scan_at = '0;
                    pending_q.insert(pending_q.size(), r);
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [31:0] mask,
                                   logic [7:0] mstate, logic [8:0] count);
            t_match_result e;
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result kind=%0d mask=%h state=%0d count=%0d",
                             $realtime, kind, mask, mstate, count);
                return;
            end
            e = pending_q.pop_front();
            case (e.kind)
                KIND_BUILD_OK, KIND_BUILD_FAIL: begin
                    if (kind == KIND_BUILD_OK) builds_ok++;
                    else builds_failed++;
                end
                KIND_SCAN: if (e.mask != 0) scans_hit++;
                default: scans_rejected++;
            endcase
            if (kind !== e.kind || mask !== e.mask || mstate !== e.mstate ||
                count !== e.count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp kind=%0d mask=%h state=%0d count=%0d,",
                             $realtime, e.kind, e.mask, e.mstate, e.count);
                    $display("    got kind=%0d mask=%h state=%0d count=%0d",
                             kind, mask, mstate, count);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic [1:0]  i_opcode;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        busy;
    logic        o_strobe;
    logic [1:0]  o_result_kind;
    logic [31:0] o_match_mask;
    logic [7:0]  o_machine_state;
    logic [8:0]  o_state_count;

    match_scoreboard matcher_sb;
    int unsigned     items_sent;
    int unsigned     idle_pct;
    int unsigned     quiet_cycles = 0;
    int unsigned     clears_sent;

    multi_pattern_byte_matcher_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_opcode       (i_opcode),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .busy           (busy),
        .o_strobe       (o_strobe),
        .o_result_kind  (o_result_kind),
        .o_match_mask   (o_match_mask),
        .o_machine_state(o_machine_state),
        .o_state_count  (o_state_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            matcher_sb.check_result(o_result_kind, o_match_mask, o_machine_state,
                                    o_state_count);
        if (i_rst_n && ((start && !busy) || o_strobe)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] sym, logic fin);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(99, 0) < idle_pct) gap = $urandom_range(6, 1);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_data_byte <= sym;
        i_last <= fin;
        do @(posedge i_clk); while (busy);
        matcher_sb.note_item(op, sym, fin);
        items_sent++;
        if (op == OP_CLEAR) clears_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (matcher_sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    // mostly a three-letter alphabet so patterns overlap
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99, 0) < 80) return 8'($urandom_range(99, 97));
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic load_pattern(int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            send_item(OP_LOAD, pick_byte(), k == len - 1);
    endtask

    task automatic scan_queries(int unsigned total);
        int unsigned len;
        while (total > 0) begin
            len = $urandom_range(12, 1);
            if (len > total) len = total;
            for (int unsigned k = 0; k < len; k++)
                send_item(OP_SCAN, pick_byte(), k == len - 1);
            total -= len;
        end
    endtask

    task automatic normal_session();
        repeat ($urandom_range(4, 1)) begin
            repeat ($urandom_range(5, 1)) load_pattern($urandom_range(5, 1));
            if ($urandom_range(3, 0) == 0) send_item(OP_SCAN, pick_byte(), 1'($urandom));
            send_item(OP_BUILD, 8'($urandom), 1'($urandom));
            scan_queries($urandom_range(60, 30));
        end
    endtask

    // all 32 slots used (mask bit 31), then one pattern too many
    task automatic pattern_limit_session();
        for (int p = 0; p < MAX_PATTERNS; p++) begin
            if (p % 4 == 0) send_item(OP_LOAD, 8'($urandom_range(255, 0)), 1'b0);
            send_item(OP_LOAD, 8'(p * 8 + $urandom_range(7, 0)), 1'b1);
        end
        send_item(OP_BUILD, 8'h00, 1'b0);
        for (int k = 0; k < 60; k++)
            send_item(OP_SCAN, 8'($urandom_range(255, 0)), k % 7 == 6);
        send_item(OP_LOAD, 8'hff, 1'b0);
        send_item(OP_LOAD, 8'h01, 1'b1);
        send_item(OP_BUILD, 8'hff, 1'b1);
        scan_queries(10);
    endtask

    // one long pattern runs the state store out
    task automatic state_limit_session();
        for (int k = 0; k < MAX_STATES + 3; k++)
            send_item(OP_LOAD, 8'($urandom_range(255, 0)), k == MAX_STATES + 2);
        send_item(OP_BUILD, 8'h00, 1'b0);
        scan_queries(8);
        load_pattern(2);
        send_item(OP_BUILD, 8'h00, 1'b1);
    endtask

    initial begin
        int unsigned session;
        int unsigned pct_table [3];
        pct_table = '{0, 58, 24};
        matcher_sb = new();
        items_sent = 0;
        clears_sent = 0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_CLEAR;
        i_data_byte = '0;
        i_last = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        send_item(OP_SCAN, 8'h00, 1'b0);
        send_item(OP_SCAN, 8'hff, 1'b1);
        send_item(OP_BUILD, 8'h00, 1'b0);
        send_item(OP_SCAN, 8'hff, 1'b0);
        send_item(OP_SCAN, 8'h00, 1'b1);
        send_item(OP_LOAD, 8'hff, 1'b0);
        send_item(OP_LOAD, 8'h00, 1'b1);
        send_item(OP_LOAD, 8'h00, 1'b1);
        send_item(OP_LOAD, 8'h80, 1'b0);
        send_item(OP_LOAD, 8'hff, 1'b1);
        send_item(OP_BUILD, 8'hff, 1'b1);
        send_item(OP_SCAN, 8'h80, 1'b0);
        send_item(OP_SCAN, 8'hff, 1'b0);
        send_item(OP_SCAN, 8'h00, 1'b0);
        send_item(OP_SCAN, 8'h00, 1'b1);
        send_item(OP_SCAN, 8'h00, 1'b1);
        send_item(OP_LOAD, 8'h7f, 1'b1);
        send_item(OP_SCAN, 8'h7f, 1'b1);
        send_item(OP_BUILD, 8'h55, 1'b0);
        send_item(OP_SCAN, 8'h7f, 1'b0);
        send_item(OP_SCAN, 8'hff, 1'b1);
        drain_results();

        session = 0;
        while (items_sent < 1300) begin
            idle_pct = pct_table[session % 3];
            send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
            case (session)
                2:       pattern_limit_session();
                4:       state_limit_session();
                default: normal_session();
            endcase
            drain_results();
            session++;
        end

        start <= 1'b0;
        drain_results();
        repeat (200) @(posedge i_clk);
        $display("Ran %0d items (%0d clears) in %0d sessions: %0d results,",
                 items_sent, clears_sent, session, matcher_sb.results_seen);
        $display("builds ok/failed %0d/%0d, scans with matches %0d, rejected scans %0d",
                 matcher_sb.builds_ok, matcher_sb.builds_failed,
                 matcher_sb.scans_hit, matcher_sb.scans_rejected);
        if (matcher_sb.mismatches == 0 && matcher_sb.pending_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
